FILE: src/matrix_vector_transform_4x4_top_macros.svh
// assertion macros shared by the matrix vector transform modules
`ifndef MATRIX_VECTOR_TRANSFORM_4X4_TOP_MACROS_SVH
`define MATRIX_VECTOR_TRANSFORM_4X4_TOP_MACROS_SVH

// same-cycle implication, checked on aclk outside reset
`define MVT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define MVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mvt_pkg.sv
// shared types and constants for the matrix vector transform
`timescale 1ns / 1ps

package mvt_pkg;

    localparam int DATA_W   = 32;
    localparam int NUM_ROWS = 4;
    localparam int NUM_COLS = 4;
    localparam int PROD_W   = 2 * DATA_W;
    // four products summed exactly need two extra bits
    localparam int SUM_W    = PROD_W + 2;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_XFORM4 = 2'd1,
        ACT_XFORM3 = 2'd2,
        ACT_NONE   = 2'd3
    } mvt_action_t;

    // one item as it travels down the cell chain
    typedef struct packed {
        logic                                 load;
        logic                                 vec3;
        logic [3:0]                           elem_index;
        logic [DATA_W-1:0]                    elem_value;
        logic [NUM_COLS-1:0][DATA_W-1:0]      vec;
        logic [NUM_ROWS-1:0][SUM_W-1:0]       sum;
    } mvt_item_t;

endpackage

FILE: src/mvt_cell.sv
// one matrix column cell: holds a column, multiplies and accumulates row sums
`timescale 1ns / 1ps
`include "matrix_vector_transform_4x4_top_macros.svh"

module mvt_cell #(
    parameter int COL       = 0,
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  mvt_pkg::mvt_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output mvt_pkg::mvt_item_t out_item
);

    localparam logic [mvt_pkg::DATA_W-1:0] ONE = mvt_pkg::DATA_W'(1) << FRAC_BITS;

    logic [mvt_pkg::NUM_ROWS-1:0][mvt_pkg::DATA_W-1:0] col_reg;

    logic                                               p_valid_reg;
    logic                                               p_valid_next;
    mvt_pkg::mvt_item_t                                 p_item_reg;
    logic [mvt_pkg::NUM_ROWS-1:0][mvt_pkg::PROD_W-1:0]  p_prod_reg;
    logic [mvt_pkg::NUM_ROWS-1:0][mvt_pkg::PROD_W-1:0]  prod_next;

    logic                                               s_valid_reg;
    logic                                               s_valid_next;
    mvt_pkg::mvt_item_t                                 s_item_reg;
    mvt_pkg::mvt_item_t                                 s_item_next;

    logic p_ready;
    logic s_ready;
    logic p_load;
    logic col_write;

    // stage handshakes, a stage moves when the one after it has room
    assign s_ready   = !s_valid_reg || out_ready;
    assign p_ready   = !p_valid_reg || s_ready;
    assign in_ready  = p_ready;
    assign p_load    = in_valid && p_ready;
    assign col_write = p_load && in_item.load && (in_item.elem_index[3:2] == 2'(COL));

    assign p_valid_next = p_ready ? in_valid : p_valid_reg;
    assign s_valid_next = s_ready ? p_valid_reg : s_valid_reg;

    // products of this column with the vector component for this column
    always_comb begin
        for (int r = 0; r < mvt_pkg::NUM_ROWS; r++) begin
            prod_next[r] = $signed(col_reg[r]) * $signed(in_item.vec[COL]);
        end
    end

    // running row sums
    always_comb begin
        s_item_next = p_item_reg;
        for (int r = 0; r < mvt_pkg::NUM_ROWS; r++) begin
            s_item_next.sum[r] = p_item_reg.sum[r]
                + mvt_pkg::SUM_W'($signed(p_prod_reg[r]));
        end
    end

    // control state and column storage, column resets to its identity column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            for (int r = 0; r < mvt_pkg::NUM_ROWS; r++) begin
                col_reg[r] <= (r == COL) ? ONE : '0;
            end
        end else begin
            p_valid_reg <= p_valid_next;
            s_valid_reg <= s_valid_next;
            if (col_write) begin
                col_reg[in_item.elem_index[1:0]] <= in_item.elem_value;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (p_load) begin
            p_item_reg <= in_item;
            p_prod_reg <= prod_next;
        end
        if (p_valid_reg && s_ready) begin
            s_item_reg <= s_item_next;
        end
    end

    assign out_valid = s_valid_reg;
    assign out_item  = s_item_reg;

    `MVT_ASSERT_NEXT(a_cell_take, in_valid && in_ready, p_valid_reg, "cell lost a transfer on entry")
    `MVT_ASSERT_NEXT(a_cell_hold, p_valid_reg && !s_ready, p_valid_reg, "cell dropped a stalled item")

endmodule

FILE: src/mvt_round_sat.sv
// output stage: floor shift, saturation and result register
`timescale 1ns / 1ps
`include "matrix_vector_transform_4x4_top_macros.svh"

module mvt_round_sat #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                               aclk,
    input  logic                                               aresetn,
    input  logic                                               in_valid,
    output logic                                               in_ready,
    input  mvt_pkg::mvt_item_t                                 in_item,
    output logic                                               out_valid,
    input  logic                                               out_ready,
    output logic [mvt_pkg::NUM_ROWS-1:0][mvt_pkg::DATA_W-1:0]  out_data
);

    localparam int HI_W = mvt_pkg::SUM_W - mvt_pkg::DATA_W + 1;
    localparam logic [mvt_pkg::DATA_W-1:0] MAX_VAL = {1'b0, {(mvt_pkg::DATA_W-1){1'b1}}};
    localparam logic [mvt_pkg::DATA_W-1:0] MIN_VAL = {1'b1, {(mvt_pkg::DATA_W-1){1'b0}}};

    logic                                               out_valid_reg;
    logic                                               out_valid_next;
    logic [mvt_pkg::NUM_ROWS-1:0][mvt_pkg::DATA_W-1:0]  out_data_reg;
    logic [mvt_pkg::NUM_ROWS-1:0][mvt_pkg::DATA_W-1:0]  out_data_next;
    logic                                               out_free;
    logic                                               take;

    // loads retire here without a result
    assign out_free       = !out_valid_reg || out_ready;
    assign in_ready       = in_item.load || out_free;
    assign take           = in_valid && !in_item.load && out_free;
    assign out_valid_next = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // arithmetic shift rounds toward minus infinity, then clamp to 32 bits
    always_comb begin
        logic signed [mvt_pkg::SUM_W-1:0] shifted;
        logic [HI_W-1:0]                  hi;
        for (int r = 0; r < mvt_pkg::NUM_ROWS; r++) begin
            shifted = $signed(in_item.sum[r]) >>> FRAC_BITS;
            hi      = shifted[mvt_pkg::SUM_W-1:mvt_pkg::DATA_W-1];
            if ((&hi) || (~|hi)) begin
                out_data_next[r] = shifted[mvt_pkg::DATA_W-1:0];
            end else if (hi[HI_W-1]) begin
                out_data_next[r] = MIN_VAL;
            end else begin
                out_data_next[r] = MAX_VAL;
            end
        end
        // w row is forced to zero for three-component transforms
        if (in_item.vec3) begin
            out_data_next[mvt_pkg::NUM_ROWS-1] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `MVT_ASSERT_NEXT(a_out_take, take, out_valid_reg, "transform result not presented")
    `MVT_ASSERT_NOW(a_out_load, in_valid && in_item.load, in_ready, "load stalled at retire")

endmodule

FILE: src/matrix_vector_transform_4x4_top.sv
// top level: 4x4 matrix by vector transform over a chain of column cells
//
//  channel  dir  ports                     contents
//  s_       in   tvalid tready tdata tuser  load element or vector to transform
//  m_       out  tvalid tready tdata       transformed vector
//
// one item per cycle sustained while m_tready is high; every column cell takes a new item each cycle that it has room
// the path runs through two stages in each of the four column cells plus the output register
// reset loads the identity matrix at once, no clearing pass
// a stage holds only while the stage after it is full and stalled, so bubbles close up under stalls
// loads ride the chain so each column is written after earlier transforms have read it
`timescale 1ns / 1ps

module matrix_vector_transform_4x4_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // elem_index, elem_value, vec_x, vec_y, vec_z, vec_w, zero fill
    input  logic [167:0] s_tdata,
    // action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z, out_w
    output logic [127:0] m_tdata
);

    localparam logic [mvt_pkg::DATA_W-1:0] ONE = mvt_pkg::DATA_W'(1) << FRAC_BITS;

    mvt_pkg::mvt_action_t action;
    mvt_pkg::mvt_item_t   head_item;
    logic                 head_valid;

    logic               cell_valid [mvt_pkg::NUM_COLS+1];
    logic               cell_ready [mvt_pkg::NUM_COLS+1];
    mvt_pkg::mvt_item_t cell_item  [mvt_pkg::NUM_COLS+1];

    logic [mvt_pkg::NUM_ROWS-1:0][mvt_pkg::DATA_W-1:0] res_data;

    assign action = mvt_pkg::mvt_action_t'(s_tuser);

    // unpack the input transfer, unused action code is dropped on entry
    always_comb begin
        head_item.load       = (action == mvt_pkg::ACT_LOAD);
        head_item.vec3       = (action == mvt_pkg::ACT_XFORM3);
        head_item.elem_index = s_tdata[3:0];
        head_item.elem_value = s_tdata[35:4];
        head_item.vec[0]     = s_tdata[67:36];
        head_item.vec[1]     = s_tdata[99:68];
        head_item.vec[2]     = s_tdata[131:100];
        head_item.vec[3]     = head_item.vec3 ? ONE : s_tdata[163:132];
        head_item.sum        = '0;
    end

    assign head_valid    = s_tvalid && (action != mvt_pkg::ACT_NONE);
    assign s_tready      = cell_ready[0] || (action == mvt_pkg::ACT_NONE);
    assign cell_valid[0] = head_valid;
    assign cell_item[0]  = head_item;

    // column cells, each hands its row sums to the next
    for (genvar c = 0; c < mvt_pkg::NUM_COLS; c++) begin : g_cell
        mvt_cell #(
            .COL       (c),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_valid[c]),
            .in_ready  (cell_ready[c]),
            .in_item   (cell_item[c]),
            .out_valid (cell_valid[c+1]),
            .out_ready (cell_ready[c+1]),
            .out_item  (cell_item[c+1])
        );
    end

    // shift, saturate and hold the result
    mvt_round_sat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_round_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cell_valid[mvt_pkg::NUM_COLS]),
        .in_ready  (cell_ready[mvt_pkg::NUM_COLS]),
        .in_item   (cell_item[mvt_pkg::NUM_COLS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data)
    );

    assign m_tdata = res_data;

endmodule
